// ===== sv/mct_pkg.sv =====
package mct_pkg;

	localparam int MAX_TIMERS     = 2;
	localparam int DEF_NUM_TIMERS = 2;

	localparam int SEC_W      = 19;
	localparam int COOK_MIN_W = 13;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam logic [SEC_W-1:0]      MAX_PRESET_S = 19'd359999;
	localparam logic [COOK_MIN_W-1:0] MAX_COOK_MIN = 13'd5999;
	localparam logic [HOUR_W-1:0]     MAX_ALARM_H  = 5'd23;
	localparam logic [MINUTE_W-1:0]   MAX_ALARM_M  = 6'd59;
	localparam logic [5:0]            SECS_PER_MIN = 6'd60;

	// floor(x / 3600) = ((x >> 4) * DIV3600_MUL) >> DIV_SHIFT, exact for 19-bit x
	// floor(x / 60)   = ((x >> 2) * DIV60_MUL)   >> DIV_SHIFT, exact for 19-bit x
	localparam logic [15:0] DIV3600_MUL = 16'd37283;
	localparam logic [19:0] DIV60_MUL   = 20'd559241;
	localparam int          DIV_SHIFT   = 23;

	typedef enum logic [2:0] {
		MODE_TICK        = 3'd0,
		MODE_START_TIMER = 3'd1,
		MODE_STOP_TIMER  = 3'd2,
		MODE_START_COOK  = 3'd3,
		MODE_STOP_COOK   = 3'd4,
		MODE_ARM         = 3'd5,
		MODE_DISARM      = 3'd6,
		MODE_READ        = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		REG_TIMER0_PRESET = 3'd0,
		REG_TIMER1_PRESET = 3'd1,
		REG_COOK_PRESET   = 3'd2,
		REG_ALARM_HOUR    = 3'd3,
		REG_ALARM_MINUTE  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] expired;
		logic       fired;
		logic       cdone;
		logic [1:0] running;
		logic       cook_running;
		logic       armed;
	} status_t;

endpackage

// ===== sv/multi_countdown_timer_with_alarm.sv =====
// Each item passes the input register, then the state update and constant-divisor h:m:s split
// into the result register.
// Throughput: one item per cycle; the input register holds only while the result register is
// full and not taken.
// arst_n clears all counters, running bits, the alarm, presets and stage valids.
module multi_countdown_timer_with_alarm
	import mct_pkg::*;
#(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            mode,
	input  logic                  timer_id,
	input  logic [HOUR_W-1:0]     now_hour,
	input  logic [MINUTE_W-1:0]   now_minute,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            expired_mask,
	output logic                  delayed_start_fired,
	output logic                  cooking_done,
	output logic [1:0]            running_mask,
	output logic                  cooking_running,
	output logic                  alarm_armed,
	output logic [6:0]            readout_hours,
	output logic [5:0]            readout_minutes,
	output logic [5:0]            readout_seconds,
	output logic [6:0]            cooking_hours,
	output logic [5:0]            cooking_minutes
);

	// configuration
	logic [SEC_W-1:0]      preset_q [MAX_TIMERS];
	logic [COOK_MIN_W-1:0] cook_preset_min_q;
	logic [SEC_W-1:0]      cook_preset_s_q;
	logic [HOUR_W-1:0]     alarm_hour_q;
	logic [MINUTE_W-1:0]   alarm_minute_q;

	logic                  cfg_wr;
	reg_idx_t              cfg_idx;
	logic [SEC_W-1:0]      wr_sec;
	logic [COOK_MIN_W-1:0] wr_cook;
	logic [HOUR_W-1:0]     wr_hour;
	logic [MINUTE_W-1:0]   wr_minute;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	assign wr_sec    = (pwdata[SEC_W-1:0] > MAX_PRESET_S) ? MAX_PRESET_S : pwdata[SEC_W-1:0];
	assign wr_cook   = (pwdata[COOK_MIN_W-1:0] > MAX_COOK_MIN) ? MAX_COOK_MIN
	                 : pwdata[COOK_MIN_W-1:0];
	assign wr_hour   = (pwdata[HOUR_W-1:0] > MAX_ALARM_H) ? MAX_ALARM_H : pwdata[HOUR_W-1:0];
	assign wr_minute = (pwdata[MINUTE_W-1:0] > MAX_ALARM_M) ? MAX_ALARM_M
	                 : pwdata[MINUTE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TIMERS; i++) begin
				preset_q[i] <= '0;
			end
			cook_preset_min_q <= '0;
			cook_preset_s_q   <= '0;
			alarm_hour_q      <= '0;
			alarm_minute_q    <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TIMER0_PRESET: preset_q[0] <= wr_sec;
				REG_TIMER1_PRESET: preset_q[1] <= wr_sec;
				REG_COOK_PRESET: begin
					cook_preset_min_q <= wr_cook;
					cook_preset_s_q   <= {6'd0, wr_cook} * SEC_W'(SECS_PER_MIN);
				end
				REG_ALARM_HOUR:   alarm_hour_q   <= wr_hour;
				REG_ALARM_MINUTE: alarm_minute_q <= wr_minute;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TIMER0_PRESET: prdata = DATA_W'(preset_q[0]);
			REG_TIMER1_PRESET: prdata = DATA_W'(preset_q[1]);
			REG_COOK_PRESET:   prdata = DATA_W'(cook_preset_min_q);
			REG_ALARM_HOUR:    prdata = DATA_W'(alarm_hour_q);
			REG_ALARM_MINUTE:  prdata = DATA_W'(alarm_minute_q);
			default:           prdata = '0;
		endcase
	end

	// pipeline handshake
	logic v_s1, v_q;
	logic rdy_o, rdy1;

	assign rdy_o     = !v_q || out_ready;
	assign rdy1      = !v_s1 || rdy_o;
	assign in_ready  = rdy1;
	assign out_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy1)  v_s1 <= in_valid;
			if (rdy_o) v_q  <= v_s1;
		end
	end

	// stage 1: input register
	mode_t               mode_s1;
	logic                id_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [MINUTE_W-1:0] minute_s1;

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			mode_s1   <= mode_t'(mode);
			id_s1     <= timer_id;
			hour_s1   <= now_hour;
			minute_s1 <= now_minute;
		end
	end

	// timer state, updated as an item leaves stage 1
	logic [SEC_W-1:0] rem_q [MAX_TIMERS];
	logic [SEC_W-1:0] rem_d [MAX_TIMERS];
	logic [MAX_TIMERS-1:0] act_q, act_d;
	logic [SEC_W-1:0] cook_rem_q, cook_rem_d;
	logic             cook_act_q, cook_act_d;
	logic             pend_q, pend_d;
	status_t          st;
	logic             id_ok;
	logic [SEC_W-1:0] dec;
	logic [SEC_W-1:0] t_d, c_d;
	logic             adv1;

	assign adv1  = v_s1 && rdy_o;
	assign id_ok = int'(id_s1) < NUM_TIMERS;

	always_comb begin
		rem_d      = rem_q;
		act_d      = act_q;
		cook_rem_d = cook_rem_q;
		cook_act_d = cook_act_q;
		pend_d     = pend_q;
		st         = '0;
		dec        = '0;
		case (mode_s1)
			MODE_TICK: begin
				for (int i = 0; i < MAX_TIMERS; i++) begin
					if (i < NUM_TIMERS && act_q[i]) begin
						dec = (rem_q[i] != '0) ? rem_q[i] - 1'b1 : '0;
						rem_d[i] = dec;
						if (dec == '0) begin
							act_d[i]      = 1'b0;
							st.expired[i] = 1'b1;
						end
					end
				end
				if (pend_q && hour_s1 == alarm_hour_q && minute_s1 == alarm_minute_q) begin
					pend_d   = 1'b0;
					st.fired = 1'b1;
				end
				if (cook_act_q) begin
					cook_rem_d = (cook_rem_q != '0) ? cook_rem_q - 1'b1 : '0;
					if (cook_rem_d == '0) begin
						cook_act_d = 1'b0;
						st.cdone   = 1'b1;
					end
				end
			end
			MODE_START_TIMER: begin
				if (id_ok && preset_q[id_s1] != '0) begin
					rem_d[id_s1] = preset_q[id_s1];
					act_d[id_s1] = 1'b1;
				end
			end
			MODE_STOP_TIMER: begin
				if (id_ok) begin
					rem_d[id_s1] = '0;
					act_d[id_s1] = 1'b0;
				end
			end
			MODE_START_COOK: begin
				if (cook_preset_min_q != '0) begin
					cook_rem_d = cook_preset_s_q;
					cook_act_d = 1'b1;
				end
			end
			MODE_STOP_COOK: begin
				cook_rem_d = '0;
				cook_act_d = 1'b0;
			end
			MODE_ARM:    pend_d = 1'b1;
			MODE_DISARM: pend_d = 1'b0;
			default: ;
		endcase
		st.running      = 2'(act_d);
		st.cook_running = cook_act_d;
		st.armed        = pend_d;
		if (!id_ok) begin
			t_d = '0;
		end else if (act_d[id_s1]) begin
			t_d = rem_d[id_s1];
		end else begin
			t_d = preset_q[id_s1];
		end
		c_d = cook_act_d ? cook_rem_d : cook_preset_s_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TIMERS; i++) begin
				rem_q[i] <= '0;
			end
			act_q      <= '0;
			cook_rem_q <= '0;
			cook_act_q <= 1'b0;
			pend_q     <= 1'b0;
		end else if (adv1) begin
			rem_q      <= rem_d;
			act_q      <= act_d;
			cook_rem_q <= cook_rem_d;
			cook_act_q <= cook_act_d;
			pend_q     <= pend_d;
		end
	end

	// whole hours and whole minutes by reciprocal multiply, then remainders
	logic [30:0]      th_prod, ch_prod;
	logic [36:0]      tm_prod, cm_prod;
	logic [6:0]       t_hrs, c_hrs;
	logic [12:0]      t_min_all, c_min_all;
	logic [12:0]      t_min_full, c_min_full;
	logic [SEC_W-1:0] t_sec_full;
	status_t          st_q;

	assign th_prod = t_d[SEC_W-1:4] * DIV3600_MUL;
	assign ch_prod = c_d[SEC_W-1:4] * DIV3600_MUL;
	assign tm_prod = t_d[SEC_W-1:2] * DIV60_MUL;
	assign cm_prod = c_d[SEC_W-1:2] * DIV60_MUL;

	assign t_hrs     = th_prod[DIV_SHIFT+6:DIV_SHIFT];
	assign c_hrs     = ch_prod[DIV_SHIFT+6:DIV_SHIFT];
	assign t_min_all = tm_prod[DIV_SHIFT+12:DIV_SHIFT];
	assign c_min_all = cm_prod[DIV_SHIFT+12:DIV_SHIFT];

	assign t_min_full = t_min_all - {6'd0, t_hrs} * 13'(SECS_PER_MIN);
	assign c_min_full = c_min_all - {6'd0, c_hrs} * 13'(SECS_PER_MIN);
	assign t_sec_full = t_d - {6'd0, t_min_all} * SEC_W'(SECS_PER_MIN);

	// result register
	always_ff @(posedge clk) begin
		if (adv1) begin
			st_q            <= st;
			readout_hours   <= t_hrs;
			readout_minutes <= t_min_full[5:0];
			readout_seconds <= t_sec_full[5:0];
			cooking_hours   <= c_hrs;
			cooking_minutes <= c_min_full[5:0];
		end
	end

	assign expired_mask        = st_q.expired;
	assign delayed_start_fired = st_q.fired;
	assign cooking_done        = st_q.cdone;
	assign running_mask        = st_q.running;
	assign cooking_running     = st_q.cook_running;
	assign alarm_armed         = st_q.armed;

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mct_pkg::*;

	typedef struct packed {
		status_t    flags;
		logic [6:0] rd_h;
		logic [5:0] rd_m;
		logic [5:0] rd_s;
		logic [6:0] ck_h;
		logic [5:0] ck_m;
	} oven_view_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [ADDR_W-1:0]   paddr      = '0;
	logic [DATA_W-1:0]   pwdata     = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [2:0]          mode       = '0;
	logic                timer_id   = 1'b0;
	logic [HOUR_W-1:0]   now_hour   = '0;
	logic [MINUTE_W-1:0] now_minute = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [1:0]          expired_mask;
	logic                delayed_start_fired;
	logic                cooking_done;
	logic [1:0]          running_mask;
	logic                cooking_running;
	logic                alarm_armed;
	logic [6:0]          readout_hours;
	logic [5:0]          readout_minutes;
	logic [5:0]          readout_seconds;
	logic [6:0]          cooking_hours;
	logic [5:0]          cooking_minutes;

	// predicted block state
	logic [SEC_W-1:0]      timer_preset [MAX_TIMERS];
	logic [SEC_W-1:0]      timer_left   [MAX_TIMERS];
	logic                  timer_on     [MAX_TIMERS];
	logic [COOK_MIN_W-1:0] cook_preset;
	logic [SEC_W-1:0]      cook_left;
	logic                  cook_on;
	logic [HOUR_W-1:0]     alarm_h;
	logic [MINUTE_W-1:0]   alarm_m;
	logic                  alarm_set;

	oven_view_t  predicted_views [$];
	oven_view_t  want;
	int unsigned errors     = 0;
	int unsigned gap_pct    = 0;
	int unsigned stall_pct  = 0;
	int unsigned stall_left = 0;

	multi_countdown_timer_with_alarm DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(3_000_000);
		$display("testbench NOT OK");
		$finish;
	end

	task automatic report_mismatch(string msg);
		if (errors < 40)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
	endtask

	function automatic oven_view_t step_oven(mode_t md, logic id, logic [HOUR_W-1:0] h,
			logic [MINUTE_W-1:0] m);
		oven_view_t       v;
		logic [SEC_W-1:0] shown;
		v = '0;
		case (md)
		MODE_TICK: begin
			for (int i = 0; i < MAX_TIMERS; i++) begin
				if (timer_on[i]) begin
					if (timer_left[i] != 0)
						timer_left[i] = timer_left[i] - 1'b1;
					if (timer_left[i] == 0) begin
						timer_on[i] = 1'b0;
						v.flags.expired[i] = 1'b1;
					end
				end
			end
			if (alarm_set && h == alarm_h && m == alarm_m) begin
				alarm_set = 1'b0;
				v.flags.fired = 1'b1;
			end
			if (cook_on) begin
				if (cook_left != 0)
					cook_left = cook_left - 1'b1;
				if (cook_left == 0) begin
					cook_on = 1'b0;
					v.flags.cdone = 1'b1;
				end
			end
		end
		MODE_START_TIMER: begin
			if (timer_preset[id] != 0) begin
				timer_left[id] = timer_preset[id];
				timer_on[id] = 1'b1;
			end
		end
		MODE_STOP_TIMER: begin
			timer_on[id] = 1'b0;
			timer_left[id] = '0;
		end
		MODE_START_COOK: begin
			if (cook_preset != 0) begin
				cook_left = SEC_W'(cook_preset) * SEC_W'(SECS_PER_MIN);
				cook_on = 1'b1;
			end
		end
		MODE_STOP_COOK: begin
			cook_on = 1'b0;
			cook_left = '0;
		end
		MODE_ARM: alarm_set = 1'b1;
		MODE_DISARM: alarm_set = 1'b0;
		default: ;
		endcase
		v.flags.running = {timer_on[1], timer_on[0]};
		v.flags.cook_running = cook_on;
		v.flags.armed = alarm_set;
		shown = timer_on[id] ? timer_left[id] : timer_preset[id];
		v.rd_h = 7'(shown / 3600);
		v.rd_m = 6'((shown % 3600) / 60);
		v.rd_s = 6'(shown % 60);
		if (cook_on) begin
			v.ck_h = 7'(cook_left / 3600);
			v.ck_m = 6'((cook_left % 3600) / 60);
		end else begin
			v.ck_h = 7'(cook_preset / 60);
			v.ck_m = 6'(cook_preset % 60);
		end
		return v;
	endfunction

	function automatic void load_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		case (idx)
		REG_TIMER0_PRESET, REG_TIMER1_PRESET:
			timer_preset[idx == REG_TIMER1_PRESET] = (value[SEC_W-1:0] > MAX_PRESET_S) ?
				MAX_PRESET_S : value[SEC_W-1:0];
		REG_COOK_PRESET:
			cook_preset = (value[COOK_MIN_W-1:0] > MAX_COOK_MIN) ?
				MAX_COOK_MIN : value[COOK_MIN_W-1:0];
		REG_ALARM_HOUR:
			alarm_h = (value[HOUR_W-1:0] > MAX_ALARM_H) ? MAX_ALARM_H : value[HOUR_W-1:0];
		default:
			alarm_m = (value[MINUTE_W-1:0] > MAX_ALARM_M) ? MAX_ALARM_M : value[MINUTE_W-1:0];
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		load_reg(idx, value);
	endtask

	task automatic send_item(mode_t md, logic id, logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		timer_id <= id;
		now_hour <= h;
		now_minute <= m;
		do @(posedge clk); while (!in_ready);
		predicted_views.push_back(step_oven(md, id, h, m));
	endtask

	// hold the input side until every outstanding result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (predicted_views.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 8) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (predicted_views.size() == 0) begin
				report_mismatch("result transfer with no item outstanding");
			end else begin
				want = predicted_views.pop_front();
				check_field("expired_mask", 32'(expired_mask), 32'(want.flags.expired));
				check_field("delayed_start_fired", 32'(delayed_start_fired),
					32'(want.flags.fired));
				check_field("cooking_done", 32'(cooking_done), 32'(want.flags.cdone));
				check_field("running_mask", 32'(running_mask), 32'(want.flags.running));
				check_field("cooking_running", 32'(cooking_running),
					32'(want.flags.cook_running));
				check_field("alarm_armed", 32'(alarm_armed), 32'(want.flags.armed));
				check_field("readout_hours", 32'(readout_hours), 32'(want.rd_h));
				check_field("readout_minutes", 32'(readout_minutes), 32'(want.rd_m));
				check_field("readout_seconds", 32'(readout_seconds), 32'(want.rd_s));
				check_field("cooking_hours", 32'(cooking_hours), 32'(want.ck_h));
				check_field("cooking_minutes", 32'(cooking_minutes), 32'(want.ck_m));
			end
		end
	end

	task automatic test_reset_readout();
		send_item(MODE_READ, 1'b0, 5'd0, 6'd0);
		send_item(MODE_READ, 1'b1, 5'd31, 6'd63);
	endtask

	// all-ones writes saturate every register, then alternating bit patterns
	task automatic test_extremes();
		drain_results();
		for (int r = REG_TIMER0_PRESET; r <= REG_ALARM_MINUTE; r++)
			write_reg(reg_idx_t'(r), '1);
		send_item(MODE_READ, 1'b0, 5'd0, 6'd0);
		send_item(MODE_READ, 1'b1, 5'd0, 6'd0);
		send_item(MODE_START_TIMER, 1'b0, 5'd0, 6'd0);
		send_item(MODE_START_TIMER, 1'b1, 5'd0, 6'd0);
		send_item(MODE_START_COOK, 1'b0, 5'd0, 6'd0);
		send_item(MODE_TICK, 1'b0, 5'd0, 6'd0);
		send_item(MODE_STOP_TIMER, 1'b0, 5'd0, 6'd0);
		send_item(MODE_STOP_COOK, 1'b1, 5'd0, 6'd0);
		drain_results();
		write_reg(REG_TIMER0_PRESET, 32'h0002_AAAA);
		write_reg(REG_TIMER1_PRESET, 32'h0005_5555);
		write_reg(REG_COOK_PRESET, 32'h0000_1555);
		write_reg(REG_ALARM_HOUR, 32'h0000_0015);
		write_reg(REG_ALARM_MINUTE, 32'h0000_002A);
		send_item(MODE_READ, 1'b0, 5'd0, 6'd0);
		send_item(MODE_READ, 1'b1, 5'd0, 6'd0);
	endtask

	// timer 1 is still counting here: a start with nothing loaded must leave it alone
	task automatic test_zero_preset();
		drain_results();
		write_reg(REG_TIMER0_PRESET, '0);
		write_reg(REG_TIMER1_PRESET, '0);
		write_reg(REG_COOK_PRESET, '0);
		send_item(MODE_START_TIMER, 1'b0, 5'd0, 6'd0);
		send_item(MODE_START_TIMER, 1'b1, 5'd0, 6'd0);
		send_item(MODE_START_COOK, 1'b0, 5'd0, 6'd0);
		send_item(MODE_STOP_TIMER, 1'b1, 5'd0, 6'd0);
	endtask

	task automatic test_reload_and_expiry();
		drain_results();
		write_reg(REG_TIMER0_PRESET, 32'd1);
		write_reg(REG_TIMER1_PRESET, 32'd2);
		send_item(MODE_START_TIMER, 1'b1, 5'd0, 6'd0);
		send_item(MODE_TICK, 1'b1, 5'd0, 6'd0);
		send_item(MODE_START_TIMER, 1'b1, 5'd0, 6'd0);
		send_item(MODE_START_TIMER, 1'b0, 5'd0, 6'd0);
		send_item(MODE_TICK, 1'b1, 5'd0, 6'd0);
		send_item(MODE_TICK, 1'b0, 5'd0, 6'd0);
	endtask

	task automatic test_alarm();
		drain_results();
		write_reg(REG_ALARM_HOUR, 32'd7);
		write_reg(REG_ALARM_MINUTE, 32'd30);
		send_item(MODE_ARM, 1'b0, 5'd7, 6'd30);
		send_item(MODE_DISARM, 1'b0, 5'd7, 6'd30);
		send_item(MODE_ARM, 1'b1, 5'd7, 6'd30);
		send_item(MODE_TICK, 1'b0, 5'd7, 6'd29);
		send_item(MODE_TICK, 1'b0, 5'd31, 6'd63);
		send_item(MODE_TICK, 1'b1, 5'd7, 6'd30);
		send_item(MODE_TICK, 1'b1, 5'd7, 6'd30);
	endtask

	function automatic logic [DATA_W-1:0] rand_reg_value(reg_idx_t idx);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return $urandom;
		case (idx)
		REG_TIMER0_PRESET, REG_TIMER1_PRESET:
			return (roll == 1) ? 0 : (roll == 2) ? MAX_PRESET_S : $urandom_range(1, 40);
		REG_COOK_PRESET:
			return (roll == 1) ? 0 : (roll == 2) ? MAX_COOK_MIN : $urandom_range(1, 2);
		REG_ALARM_HOUR:
			return $urandom_range(0, 23);
		default:
			return $urandom_range(0, 59);
		endcase
	endfunction

	// mostly ticks, often on the alarm minute; cooking restarts are rare so it can finish
	task automatic send_random_item();
		int unsigned         pick;
		mode_t               md;
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] m;
		pick = $urandom_range(0, 99);
		h = HOUR_W'($urandom_range(0, 23));
		m = MINUTE_W'($urandom_range(0, 59));
		if (pick < 62)
			md = MODE_TICK;
		else if (pick < 72)
			md = MODE_START_TIMER;
		else if (pick < 77)
			md = MODE_STOP_TIMER;
		else if (pick < 80)
			md = (cook_on && $urandom_range(0, 3) != 0) ? MODE_READ : MODE_START_COOK;
		else if (pick < 82)
			md = (cook_on && $urandom_range(0, 3) != 0) ? MODE_READ : MODE_STOP_COOK;
		else if (pick < 89)
			md = MODE_ARM;
		else if (pick < 93)
			md = MODE_DISARM;
		else
			md = MODE_READ;
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			h = alarm_h;
			m = alarm_m;
		end
		3: begin
			h = HOUR_W'($urandom_range(0, 31));
			m = MINUTE_W'($urandom_range(0, 63));
		end
		default: ;
		endcase
		send_item(md, 1'($urandom_range(0, 1)), h, m);
	endtask

	task automatic test_random(int unsigned phases, int unsigned per_phase, bit with_idle);
		for (int p = 0; p < phases; p++) begin
			drain_results();
			for (int r = REG_TIMER0_PRESET; r <= REG_ALARM_MINUTE; r++)
				write_reg(reg_idx_t'(r), rand_reg_value(reg_idx_t'(r)));
			gap_pct = with_idle ? 20 * $urandom_range(0, 2) : 0;
			stall_pct = with_idle ? 20 * $urandom_range(0, 2) : 0;
			for (int k = 0; k < per_phase; k++) begin
				send_random_item();
				if ($urandom_range(0, 299) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_TIMERS; i++) begin
			timer_preset[i] = '0;
			timer_left[i] = '0;
			timer_on[i] = 1'b0;
		end
		cook_preset = '0;
		cook_left = '0;
		cook_on = 1'b0;
		alarm_h = '0;
		alarm_m = '0;
		alarm_set = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 25;
		stall_pct = 25;
		test_reset_readout();
		test_extremes();
		test_zero_preset();
		test_reload_and_expiry();
		test_alarm();
		test_random(11, 150, 1'b1);
		test_random(2, 75, 1'b0);
		drain_results();
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
